/* rtl/core/fnv_pkg.sv */
// ----------------------------------------------------------------------------
// fnv_pkg
// Shared types, constants and helper functions for the field name validator.
// ----------------------------------------------------------------------------
`default_nettype none

package fnv_pkg;

  localparam int CHAR_W      = 8;
  localparam int NAME_CNT_W  = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int VER_W       = 4;
  localparam int NUM_RSV     = 8;
  localparam int RSV_MAX_LEN = 11;

  localparam int FNV_QUEUE_DEPTH = 2;

  localparam logic [NAME_CNT_W-1:0] NAME_CNT_MAX = 6'd63;
  localparam logic [NAME_CNT_W-1:0] LEN_LIMIT_LONG  = 6'd50;
  localparam logic [NAME_CNT_W-1:0] LEN_LIMIT_SHORT = 6'd16;

  // version thresholds
  localparam logic [VER_W-1:0] VER_SHORT_LIMIT  = 4'd3;
  localparam logic [VER_W-1:0] VER_PUNCT        = 4'd5;
  localparam logic [VER_W-1:0] VER_DOT_STRICT   = 4'd6;
  localparam logic [VER_W-1:0] VER_RSV_END      = 4'd8;
  localparam logic [VER_W-1:0] VER_FULL_DOTS    = 4'd10;

  localparam logic [CHAR_W-1:0] CTRL_LIMIT = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STANDARDS_VERSION = 2'd0,
    REG_STRICT_MODE       = 2'd1,
    REG_NAME_KIND         = 2'd2,
    REG_DOT_REPORT_ENABLE = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_CODE  = 2'd1,
    KIND_NS    = 2'd2,
    KIND_AFFIX = 2'd3
  } name_kind_t;

  // what a byte does to the name state
  typedef enum logic [1:0] {
    CLS_PLAIN   = 2'd0,  // ordinary byte, clears the dot history
    CLS_BAD     = 2'd1,  // breaks a rule on its own
    CLS_SEP_DOT = 2'd2,  // dot used as separator
    CLS_REP_DOT = 2'd3   // allowed dot that gets reported
  } char_class_t;

  typedef struct packed {
    logic [VER_W-1:0] standards_version;
    logic             strict_mode;
    name_kind_t       name_kind;
    logic             dot_report_enable;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last_char;
    logic              empty_string;
  } in_item_t;

  typedef struct packed {
    logic invalid;
    logic has_dot;
  } out_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last_char;
    logic              empty_string;
    char_class_t       cls;
  } cls_item_t;

  // reserved words, left aligned, padded with spaces to the longest one
  localparam logic [8*RSV_MAX_LEN-1:0] RSV_WORD [NUM_RSV] = '{
    "FRAMEOFFSET", "ENCODING   ", "ENDIAN     ", "INCLUDE    ",
    "META       ", "VERSION    ", "PROTECT    ", "REFERENCE  "
  };
  localparam logic [NAME_CNT_W-1:0] RSV_LEN [NUM_RSV] = '{
    6'd11, 6'd8, 6'd6, 6'd7, 6'd4, 6'd7, 6'd7, 6'd9
  };
  localparam logic [VER_W-1:0] RSV_MIN_VER [NUM_RSV] = '{
    4'd1, 4'd6, 4'd5, 4'd3, 4'd6, 4'd5, 4'd6, 4'd6
  };

  function automatic logic [CHAR_W-1:0] rsv_char(input int k,
                                                 input logic [NAME_CNT_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    c = '0;
    for (int i = 0; i < RSV_MAX_LEN; i++) begin
      if (pos == NAME_CNT_W'(i)) begin
        c = RSV_WORD[k][CHAR_W*(RSV_MAX_LEN-1-i) +: CHAR_W];
      end
    end
    return c;
  endfunction

  // unless strict below version 10, code names start as if after a dot, so a leading dot is an error
  function automatic logic start_dot(input cfg_t c);
    return (c.name_kind == KIND_CODE) &&
           (!c.strict_mode || (c.standards_version >= VER_FULL_DOTS));
  endfunction

  function automatic logic dots_are_sep(input cfg_t c);
    return (c.name_kind == KIND_NS) || start_dot(c);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/fnv_front.sv */
// ----------------------------------------------------------------------------
// fnv_front
// Input side: takes name bytes and sorts each into a byte class.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_front
  import fnv_pkg::*;
(
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire cfg_t      cfg,
  output logic           q_valid,
  input  wire logic      q_ready,
  output cls_item_t      q_data
);

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

  logic [CHAR_W-1:0] c;
  logic always_bad;
  logic strict_bad;
  logic dot_bad;
  char_class_t cls;

  assign c = in_data.ch;

  // slash, control bytes and the upper half are never allowed
  assign always_bad = (c == CH_SLASH) || (c < CTRL_LIMIT) || c[CHAR_W-1];

  assign strict_bad = cfg.strict_mode &&
    ((cfg.standards_version >= VER_PUNCT &&
      (c == CH_LT || c == CH_GT || c == CH_SEMI || c == CH_PIPE || c == CH_AMP)) ||
     (cfg.standards_version == VER_PUNCT && (c == CH_BSL || c == CH_HASH)));

  assign dot_bad = (cfg.name_kind == KIND_AFFIX) || !cfg.dot_report_enable ||
                   (cfg.strict_mode && cfg.standards_version >= VER_DOT_STRICT);

  always_comb begin
    if (always_bad || strict_bad) begin
      cls = CLS_BAD;
    end else if (c == CH_DOT) begin
      if (dots_are_sep(cfg)) begin
        cls = CLS_SEP_DOT;
      end else if (dot_bad) begin
        cls = CLS_BAD;
      end else begin
        cls = CLS_REP_DOT;
      end
    end else begin
      cls = CLS_PLAIN;
    end
  end

  assign q_valid             = in_valid;
  assign in_ready            = q_ready;
  assign q_data.ch           = in_data.ch;
  assign q_data.last_char    = in_data.last_char;
  assign q_data.empty_string = in_data.empty_string;
  assign q_data.cls          = cls;

endmodule

`default_nettype wire

/* rtl/core/fnv_queue.sv */
// ----------------------------------------------------------------------------
// fnv_queue
// Small register FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_queue
  import fnv_pkg::*;
#(
  parameter int DEPTH = FNV_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire cls_item_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output cls_item_t      rd_data
);

  localparam int QPTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);

  cls_item_t           mem [DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                wr_fire;
  logic                rd_fire;

  assign wr_ready = (fill != QCNT_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_fire) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_fire && !rd_fire) begin
        fill <= fill + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(DEPTH))
    else $error("queue fill above depth");

  a_fill_drop: assert property (@(posedge clk) disable iff (rst)
    rd_fire && !wr_fire |=> fill == $past(fill) - 1'b1)
    else $error("queue fill did not drop on read");

endmodule

`default_nettype wire

/* rtl/core/fnv_back.sv */
// ----------------------------------------------------------------------------
// fnv_back
// Name state per byte and the verdict register at the end of a name.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_back
  import fnv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      q_valid,
  output logic           q_ready,
  input  wire cls_item_t q_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic                  error_seen;
  logic                  prev_dot;
  logic                  dot_seen;
  logic [NAME_CNT_W-1:0] char_count;
  logic [NUM_RSV-1:0]    rsv_match;

  logic                  fin;
  logic                  step;
  logic                  prev_in;
  logic                  error_seen_next;
  logic                  prev_dot_next;
  logic                  dot_seen_next;
  logic [NAME_CNT_W-1:0] char_count_next;
  logic [NUM_RSV-1:0]    rsv_match_next;

  logic                  e_err;
  logic                  e_prev;
  logic                  e_dot;
  logic [NAME_CNT_W-1:0] e_count;
  logic [NUM_RSV-1:0]    e_rsv;
  logic                  rsv_hit;
  logic                  verdict;

  assign fin     = q_data.last_char || q_data.empty_string;
  // a byte in mid name never waits on the output
  assign step    = q_valid && (!fin || !out_valid || out_ready);
  assign q_ready = step;

  assign prev_in = (char_count == '0) ? start_dot(cfg) : prev_dot;

  always_comb begin
    for (int k = 0; k < NUM_RSV; k++) begin
      rsv_match_next[k] = rsv_match[k] && (char_count < RSV_LEN[k]) &&
                          (rsv_char(k, char_count) == q_data.ch);
    end
  end

  assign char_count_next = (char_count == NAME_CNT_MAX) ? char_count
                                                        : char_count + 1'b1;

  always_comb begin
    error_seen_next = error_seen;
    prev_dot_next   = prev_in;
    dot_seen_next   = dot_seen;
    case (q_data.cls)
      CLS_BAD: begin
        error_seen_next = 1'b1;
      end
      CLS_SEP_DOT: begin
        error_seen_next = error_seen || prev_in;
        prev_dot_next   = 1'b1;
      end
      CLS_REP_DOT: begin
        dot_seen_next = 1'b1;
      end
      CLS_PLAIN: begin
        prev_dot_next = 1'b0;
      end
      default: begin
        error_seen_next = 1'b1;
      end
    endcase
  end

  // empty name: everything gathered so far is dropped
  assign e_err   = q_data.empty_string ? 1'b0 : error_seen_next;
  assign e_prev  = q_data.empty_string ? start_dot(cfg) : prev_dot_next;
  assign e_dot   = q_data.empty_string ? 1'b0 : dot_seen_next;
  assign e_count = q_data.empty_string ? '0 : char_count_next;
  assign e_rsv   = q_data.empty_string ? '0 : rsv_match_next;

  always_comb begin
    rsv_hit = 1'b0;
    for (int k = 0; k < NUM_RSV; k++) begin
      if (e_rsv[k] && (e_count == RSV_LEN[k]) &&
          (cfg.standards_version >= RSV_MIN_VER[k])) begin
        rsv_hit = 1'b1;
      end
    end
  end

  always_comb begin
    verdict = e_err;
    if (cfg.name_kind == KIND_NAME) begin
      if (e_count == '0) begin
        verdict = 1'b1;
      end
      if (cfg.strict_mode &&
          ((e_count > LEN_LIMIT_LONG && cfg.standards_version < VER_PUNCT) ||
           (e_count > LEN_LIMIT_SHORT && cfg.standards_version < VER_SHORT_LIMIT))) begin
        verdict = 1'b1;
      end
      if (cfg.strict_mode && cfg.standards_version < VER_RSV_END && rsv_hit) begin
        verdict = 1'b1;
      end
    end
    if (cfg.name_kind == KIND_CODE && e_prev) begin
      verdict = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen <= 1'b0;
      prev_dot   <= 1'b0;
      dot_seen   <= 1'b0;
      char_count <= '0;
      rsv_match  <= '1;
      out_valid  <= 1'b0;
    end else begin
      if (step) begin
        if (fin) begin
          error_seen <= 1'b0;
          prev_dot   <= 1'b0;
          dot_seen   <= 1'b0;
          char_count <= '0;
          rsv_match  <= '1;
        end else begin
          error_seen <= error_seen_next;
          prev_dot   <= prev_dot_next;
          dot_seen   <= dot_seen_next;
          char_count <= char_count_next;
          rsv_match  <= rsv_match_next;
        end
      end
      if (step && fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && fin) begin
      out_data.invalid <= verdict;
      out_data.has_dot <= !verdict && e_dot;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    step && fin |=> char_count == '0 && !error_seen && !dot_seen && rsv_match == '1)
    else $error("name state not cleared after last byte");

  a_dot_only_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.invalid && out_data.has_dot))
    else $error("dot reported on an invalid name");

  a_empty_plain: assert property (@(posedge clk) disable iff (rst)
    step && q_data.empty_string && cfg.name_kind == KIND_NAME
      |=> out_valid && out_data.invalid)
    else $error("empty plain name not flagged");

endmodule

`default_nettype wire

/* rtl/core/field_name_validator.sv */
// Path: after the transfer of the last byte, a verdict passes the queue register
//   and then the verdict register before it is offered.
// Throughput: one byte per cycle while nothing stalls, set by the back end's
//   per-byte update; while a verdict waits, a last byte holds in the queue and
//   the input stalls once the queue is full.
// Reset: synchronous, active high; registers to version 10, strict, code, dots on.
// ----------------------------------------------------------------------------
// field_name_validator
// Checks a name one byte per transfer and reports invalid / has_dot at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module field_name_validator
  import fnv_pkg::*;
#(
  parameter int QUEUE_DEPTH = FNV_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // name bytes
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // verdicts
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  cfg_t      cfg;
  logic      fq_valid;
  logic      fq_ready;
  cls_item_t fq_data;
  logic      qb_valid;
  logic      qb_ready;
  cls_item_t qb_data;

  // Registers take a write in any cycle; the user must write only while no byte
  // is in flight (not enforced), so front and back see the same settings for a byte.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.standards_version <= VER_FULL_DOTS;
      cfg.strict_mode       <= 1'b1;
      cfg.name_kind         <= KIND_CODE;
      cfg.dot_report_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_STANDARDS_VERSION: cfg.standards_version <= cfg_data[VER_W-1:0];
        REG_STRICT_MODE:       cfg.strict_mode       <= cfg_data[0];
        REG_NAME_KIND:         cfg.name_kind         <= name_kind_t'(cfg_data[1:0]);
        REG_DOT_REPORT_ENABLE: cfg.dot_report_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: sorts each byte into a class against the current settings.
  fnv_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // Queue decouples byte intake from a verdict stalled at the output.
  fnv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Back: sticky error, dot history, length, reserved word tracking, verdict.
  fnv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
